FILE: src/rgb_conv3x3_clamp_unit_macros.svh
// rgb_conv3x3_clamp_unit_macros.svh
// Assertion shorthands for the checker of the 3x3 RGB convolution unit.
// Expects signals named clk and rst in the scope of use.
`ifndef RGB_CONV3X3_CLAMP_UNIT_MACROS_SVH
`define RGB_CONV3X3_CLAMP_UNIT_MACROS_SVH

// Property checked outside reset
`define RCC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers the reset cycles
`define RCC_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rcc_pkg.sv
// rcc_pkg.sv
// Types and fixed constants of the 3x3 RGB convolution unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package rcc_pkg;

  // Pixel and channel geometry
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int CH_N   = 3;
  localparam int TAP_W  = 8;
  localparam int KER    = 3;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // Arithmetic widths: 9b signed pixel x 8b tap, 3-term and 9-term sums
  localparam int PROD_W = 17;
  localparam int RSUM_W = 19;
  localparam int SUM_W  = 20;

  // Register field widths
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int COEF_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 3;

  // Compare width for the width clamp (covers MAX_WIDTH up to 8192)
  localparam int GEOM_W    = 14;
  // Input row counter runs one row past the frame while draining
  localparam int ROW_W     = 13;
  localparam int OUT_ROW_W = 12;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Register reset values
  localparam logic [FW_W-1:0]   FW_RESET       = 11'd1024;
  localparam logic [FH_W-1:0]   FH_RESET       = 13'd768;
  localparam logic [COEF_W-1:0] COEF_TOP_RESET = 24'd0;
  localparam logic [COEF_W-1:0] COEF_MID_RESET = 24'd256;
  localparam logic [COEF_W-1:0] COEF_BOT_RESET = 24'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT
  } rcc_reg_t;

  typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   pixel_red;
    logic [CH_W-1:0]   pixel_green;
    logic [CH_W-1:0]   pixel_blue;
  } rcc_pix_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
    logic              out_last;
  } rcc_res_t;

  typedef struct packed {
    logic [FW_W-1:0]   frame_width;
    logic [FH_W-1:0]   frame_height;
    logic [COEF_W-1:0] coef_row_top;
    logic [COEF_W-1:0] coef_row_mid;
    logic [COEF_W-1:0] coef_row_bot;
  } rcc_cfg_t;

  // Per-beat control word decided by the front
  typedef struct packed {
    logic emit;
    logic last;
    logic use_top;
    logic use_bot;
    logic use_left;
    logic use_right;
  } rcc_ctrl_t;

endpackage

FILE: src/rcc_front.sv
// rcc_front.sv
// Front end: accepts pixel beats, classifies them, tracks frame position.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int QW = $bits(rcc_pkg::rcc_ctrl_t) + rcc_pkg::PIX_W + CW
) (
  input  logic              clk,
  input  logic              rst,
  input  rcc_pkg::rcc_cfg_t cfg,
  input  logic              restart,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  rcc_pkg::rcc_pix_t pix_data,
  output logic              q_push,
  output logic [QW-1:0]     q_data,
  input  logic              q_full
);

  localparam logic [rcc_pkg::GEOM_W-1:0] MAXW_G = rcc_pkg::GEOM_W'(MAX_WIDTH);

  logic [CW-1:0]                   in_col, in_col_next;
  logic [rcc_pkg::ROW_W-1:0]       in_row, in_row_next;
  logic [CW-1:0]                   out_col, out_col_next;
  logic [rcc_pkg::OUT_ROW_W-1:0]   out_row, out_row_next;

  logic [WW-1:0]                   eff_w;
  logic [rcc_pkg::FH_W-1:0]        eff_h;
  logic [rcc_pkg::GEOM_W-1:0]      fw_ext;
  logic [WW-1:0]                   in_col_inc, out_col_inc;
  logic [rcc_pkg::ROW_W-1:0]       out_row_inc;
  logic                            in_col_end, out_col_end;
  logic                            inputs_done, is_flush, drop, accept;
  logic [rcc_pkg::PIX_W-1:0]       pix;
  rcc_pkg::rcc_ctrl_t              ctrl;

  // Effective geometry: zero width or height acts as one, width capped
  assign fw_ext = rcc_pkg::GEOM_W'(cfg.frame_width);
  always_comb begin
    if (cfg.frame_width == '0) begin
      eff_w = WW'(1);
    end else if (fw_ext > MAXW_G) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_ext);
    end
  end
  assign eff_h = (cfg.frame_height == '0) ? rcc_pkg::FH_W'(1) : cfg.frame_height;

  // Position compares
  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign out_row_inc = rcc_pkg::ROW_W'(out_row) + rcc_pkg::ROW_W'(1);
  assign in_col_end  = in_col_inc >= eff_w;
  assign out_col_end = out_col_inc >= eff_w;

  // Classify: flush beats before frame end are swallowed, pixels past it drain
  assign inputs_done = in_row >= eff_h;
  assign is_flush    = pix_data.kind || inputs_done;
  assign drop        = pix_data.kind && !inputs_done;
  assign accept      = pix_valid && !q_full;
  assign pix_stall   = q_full;
  assign q_push      = accept && !drop;

  assign pix = is_flush ? '0 : {pix_data.pixel_blue, pix_data.pixel_green, pix_data.pixel_red};

  // Output position flags; the first result lags one row plus one pixel
  always_comb begin
    ctrl.emit      = (in_row >= rcc_pkg::ROW_W'(2))
                  || (in_row == rcc_pkg::ROW_W'(1) && in_col != '0);
    ctrl.last      = (out_row_inc >= eff_h) && out_col_end;
    ctrl.use_top   = out_row != '0;
    ctrl.use_bot   = out_row_inc < eff_h;
    ctrl.use_left  = out_col != '0;
    ctrl.use_right = !out_col_end;
  end

  assign q_data = {ctrl, pix, in_col};

  // Counter update
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (restart) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (q_push) begin
      if (in_col_end) begin
        in_col_next = '0;
        in_row_next = in_row + rcc_pkg::ROW_W'(1);
      end else begin
        in_col_next = in_col_inc[CW-1:0];
      end
      if (ctrl.emit) begin
        if (out_col_end) begin
          out_col_next = '0;
          out_row_next = out_row_inc[rcc_pkg::OUT_ROW_W-1:0];
        end else begin
          out_col_next = out_col_inc[CW-1:0];
        end
        if (ctrl.last) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

endmodule

FILE: src/rcc_queue.sv
// rcc_queue.sv
// Short FIFO that decouples the front end from the compute back end.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0]                slots [rcc_pkg::QUEUE_DEPTH];
  logic [rcc_pkg::QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [rcc_pkg::QUEUE_CNT_W-1:0]  count, count_next;
  logic                             do_push, do_pop;

  assign full       = count == rcc_pkg::QUEUE_CNT_W'(rcc_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + rcc_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - rcc_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + rcc_pkg::QUEUE_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + rcc_pkg::QUEUE_PTR_W'(1);
      count <= count_next;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: src/rcc_back.sv
// rcc_back.sv
// Back end: line stores, 3x3 window, multiply, sum, clamp, result register.
// Depends on rcc_pkg.
`timescale 1ns / 1ps

module rcc_back #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int QW = $bits(rcc_pkg::rcc_ctrl_t) + rcc_pkg::PIX_W + CW
) (
  input  logic              clk,
  input  logic              rst,
  input  rcc_pkg::rcc_cfg_t cfg,
  input  logic              q_valid,
  input  logic [QW-1:0]     q_data,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output rcc_pkg::rcc_res_t res_data
);

  localparam int CTRL_W = $bits(rcc_pkg::rcc_ctrl_t);
  localparam int PW     = rcc_pkg::PIX_W;
  localparam int CHW    = rcc_pkg::CH_W;
  localparam int NCH    = rcc_pkg::CH_N;
  localparam int K      = rcc_pkg::KER;

  // Whole pipeline moves together unless the result register is blocked
  logic en;

  rcc_pkg::rcc_ctrl_t q_ctrl;
  logic [PW-1:0]      q_pix;
  logic [CW-1:0]      q_col;

  // Stage 1: line store read
  logic               s1_valid;
  rcc_pkg::rcc_ctrl_t s1_ctrl;
  logic [PW-1:0]      s1_pix;
  logic [CW-1:0]      s1_col;
  logic [2*PW-1:0]    line_mem [MAX_WIDTH];
  logic [2*PW-1:0]    rd_word, wr_word;
  logic [PW-1:0]      rd_a, rd_b;

  // Stage 2: window
  logic               s2_valid;
  rcc_pkg::rcc_ctrl_t s2_ctrl;
  logic [PW-1:0]      win [K][K];

  // Stage 3: products
  logic               s3_valid, s3_last;
  logic signed [rcc_pkg::PROD_W-1:0] prod      [NCH][K][K];
  logic signed [rcc_pkg::PROD_W-1:0] prod_next [NCH][K][K];

  // Stage 4: row sums
  logic               s4_valid, s4_last;
  logic signed [rcc_pkg::RSUM_W-1:0] rsum      [NCH][K];
  logic signed [rcc_pkg::RSUM_W-1:0] rsum_next [NCH][K];

  logic [rcc_pkg::COEF_W-1:0] coef_row [K];
  logic                       use_row  [K];
  logic                       use_col  [K];
  logic [CHW-1:0]             chan_out [NCH];

  assign en = !res_valid || !res_stall;

  assign {q_ctrl, q_pix, q_col} = q_data;
  assign q_pop = en && q_valid;

  // Store word holds {row above, two rows above}; new word shifts them down
  assign rd_a    = rd_word[2*PW-1:PW];
  assign rd_b    = rd_word[PW-1:0];
  assign wr_word = {s1_pix, rd_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctrl <= q_ctrl;
      s1_pix  <= q_pix;
      s1_col  <= q_col;
    end
  end

  // Line store: write-first so a one-pixel-wide frame sees its own update
  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid) line_mem[s1_col] <= wr_word;
      if (s1_valid && s1_col == q_col) begin
        rd_word <= wr_word;
      end else begin
        rd_word <= line_mem[q_col];
      end
    end
  end

  // Window shift: new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int i = 0; i < K; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= rd_b;
        win[1][2] <= rd_a;
        win[2][2] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) s2_ctrl <= s1_ctrl;
  end

  // Taps and edge masks
  always_comb begin
    coef_row[0] = cfg.coef_row_top;
    coef_row[1] = cfg.coef_row_mid;
    coef_row[2] = cfg.coef_row_bot;
    use_row[0]  = s2_ctrl.use_top;
    use_row[1]  = 1'b1;
    use_row[2]  = s2_ctrl.use_bot;
    use_col[0]  = s2_ctrl.use_left;
    use_col[1]  = 1'b1;
    use_col[2]  = s2_ctrl.use_right;
  end

  // 27 small signed multiplies, outside taps forced to zero
  always_comb begin
    logic signed [rcc_pkg::TAP_W-1:0]  tap_v;
    logic signed [CHW:0]               pv;
    logic signed [rcc_pkg::PROD_W-1:0] p_v;
    tap_v = '0;
    pv    = '0;
    p_v   = '0;
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          tap_v = coef_row[i][rcc_pkg::TAP_W*j +: rcc_pkg::TAP_W];
          pv    = {1'b0, win[i][j][CHW*c +: CHW]};
          p_v   = pv * tap_v;
          prod_next[c][i][j] = (use_row[i] && use_col[j]) ? p_v : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid && s2_ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_ctrl.last;
      prod    <= prod_next;
    end
  end

  // Row sums
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < K; i++) begin
        rsum_next[c][i] = rcc_pkg::RSUM_W'(prod[c][i][0])
                        + rcc_pkg::RSUM_W'(prod[c][i][1])
                        + rcc_pkg::RSUM_W'(prod[c][i][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_last <= s3_last;
      rsum    <= rsum_next;
    end
  end

  // Final sum and clamp to 0..255
  always_comb begin
    logic signed [rcc_pkg::SUM_W-1:0] tot;
    tot = '0;
    for (int c = 0; c < NCH; c++) begin
      tot = rcc_pkg::SUM_W'(rsum[c][0]) + rcc_pkg::SUM_W'(rsum[c][1])
          + rcc_pkg::SUM_W'(rsum[c][2]);
      if (tot < 0) begin
        chan_out[c] = '0;
      end else if (tot > rcc_pkg::SUM_W'(rcc_pkg::CH_MAX)) begin
        chan_out[c] = rcc_pkg::CH_MAX;
      end else begin
        chan_out[c] = tot[CHW-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data.out_red   <= chan_out[0];
      res_data.out_green <= chan_out[1];
      res_data.out_blue  <= chan_out[2];
      res_data.out_last  <= s4_last;
    end
  end

endmodule

FILE: src/rgb_conv3x3_clamp_unit.sv
// rgb_conv3x3_clamp_unit.sv
// Top level: register file, front end, queue and back end of the unit.
// Depends on rcc_pkg, rcc_front, rcc_queue, rcc_back.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-------------------------------
//  pix     | in        | pix_valid/pix_stall  | rcc_pix_t (kind + RGB pixel)
//  res     | out       | res_valid/res_stall  | rcc_res_t (RGB result + last)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One pixel beat per clock while no stall holds; the line store (one read and
// one write a cycle) and the window pipeline both run at that rate.
// A result passes the queue, line read, window, product, row-sum and result
// registers; in beats, result k follows input beat k + width + 1.
// rst is synchronous: counters, queue, valids and registers return to reset.
// res_stall freezes the back end; the 4-beat queue absorbs, then pix_stall.
`timescale 1ns / 1ps

module rgb_conv3x3_clamp_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  rcc_pkg::rcc_pix_t                   pix_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output rcc_pkg::rcc_res_t                   res_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(rcc_pkg::rcc_ctrl_t) + rcc_pkg::PIX_W + CW;

  rcc_pkg::rcc_cfg_t cfg;
  logic              cfg_write, restart;
  logic              q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]     q_in, q_out;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Geometry writes restart the frame position
  always_comb begin
    case (rcc_pkg::rcc_reg_t'(cfg_index))
      rcc_pkg::REG_FRAME_WIDTH,
      rcc_pkg::REG_FRAME_HEIGHT: restart = cfg_write;
      default:                   restart = 1'b0;
    endcase
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= rcc_pkg::FW_RESET;
      cfg.frame_height <= rcc_pkg::FH_RESET;
      cfg.coef_row_top <= rcc_pkg::COEF_TOP_RESET;
      cfg.coef_row_mid <= rcc_pkg::COEF_MID_RESET;
      cfg.coef_row_bot <= rcc_pkg::COEF_BOT_RESET;
    end else if (cfg_write) begin
      case (rcc_pkg::rcc_reg_t'(cfg_index))
        rcc_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[rcc_pkg::FW_W-1:0];
        rcc_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[rcc_pkg::FH_W-1:0];
        rcc_pkg::REG_COEF_TOP:     cfg.coef_row_top <= cfg_data[rcc_pkg::COEF_W-1:0];
        rcc_pkg::REG_COEF_MID:     cfg.coef_row_mid <= cfg_data[rcc_pkg::COEF_W-1:0];
        rcc_pkg::REG_COEF_BOT:     cfg.coef_row_bot <= cfg_data[rcc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  rcc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .restart   (restart),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  rcc_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out)
  );

  rcc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

FILE: src/rcc_checker.sv
// rcc_checker.sv
// Port-level assertions for the 3x3 RGB convolution unit, bound to the top.
// Depends on rcc_pkg and rgb_conv3x3_clamp_unit_macros.svh.
`timescale 1ns / 1ps
`include "rgb_conv3x3_clamp_unit_macros.svh"

module rcc_checker (
  input logic              clk,
  input logic              rst,
  input logic              pix_stall,
  input logic              res_valid,
  input logic              res_stall,
  input rcc_pkg::rcc_res_t res_data
);

  // Reset empties the result register
  `RCC_CHECK_RST(a_reset_clears, rst |=> !res_valid, "result valid after reset")

  // A blocked result beat holds
  `RCC_CHECK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "result changed while stalled")

  // The input only backs up when the result side blocked the cycle before
  `RCC_CHECK(a_stall_cause, pix_stall |-> $past(res_valid && res_stall), "input stalled without output backpressure")

  // A full queue always has a result waiting at the output
  `RCC_CHECK(a_stall_has_result, pix_stall |-> res_valid, "input stalled with empty result register")

endmodule

bind rgb_conv3x3_clamp_unit rcc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
